>>> sv/pid_controller_tustin_clamped_top_defines.svh
// assertion helpers shared by the rtl
`ifndef PID_CONTROLLER_TUSTIN_CLAMPED_TOP_DEFINES_SVH
`define PID_CONTROLLER_TUSTIN_CLAMPED_TOP_DEFINES_SVH

// same-cycle implication
`define PIDT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PIDT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/pidt_pkg.sv
package pidt_pkg;

	localparam int DATA_FRAC_BITS      = 10;
	localparam int COEF_FRAC_BITS_DEF  = 16;

	localparam int ERR_W      = 16;
	localparam int DRV_W      = 15;
	localparam int HIST_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_RATIO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE       = 3'd4;

	localparam logic [15:0] GAIN_RST         = 16'd256;
	localparam logic [23:0] INTEGRAL_RST     = 24'd100000;
	localparam logic [23:0] DERIVATIVE_RST   = 24'd0;
	localparam logic [15:0] FILTER_RATIO_RST = 16'd6554;
	localparam logic [16:0] SAMPLE_RST       = 17'd1000;

	localparam logic [DRV_W-1:0] DRIVE_LIMIT = DRV_W'(12 << DATA_FRAC_BITS);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_AD,
		OP_DEN,
		OP_K1,
		OP_N0,
		OP_TT,
		OP_DI,
		OP_N1,
		OP_OUTER,
		OP_N2,
		OP_Q0,
		OP_Q1,
		OP_Q2,
		OP_Q3,
		OP_Q4
	} op_t;

	typedef enum logic [4:0] {
		ST_AD,
		ST_DEN,
		ST_K1,
		ST_N0,
		ST_Q0,
		ST_TT,
		ST_DI,
		ST_N1,
		ST_Q1,
		ST_OUTER,
		ST_N2,
		ST_Q2,
		ST_Q3,
		ST_Q4,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_RND,
		ST_WR
	} state_t;

	typedef struct packed {
		op_t        op;
		logic       start;
		logic       in_ready;
		logic       cfg_ready;
		logic       in_load;
		logic       cfg_load;
		logic       mac;
		logic [2:0] k;
		logic       acc_clr;
		logic       rnd;
		logic       wr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} dp_sts_t;

endpackage

>>> sv/pidt_error_if.sv
interface pidt_error_if import pidt_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [ERR_W-1:0] error;

	modport source (output valid, output error, input ready);
	modport sink (input valid, input error, output ready);
endinterface

>>> sv/pidt_drive_if.sv
interface pidt_drive_if import pidt_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [DRV_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

>>> sv/pidt_cfg_if.sv
interface pidt_cfg_if import pidt_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/pidt_ctrl.sv
`include "pid_controller_tustin_clamped_top_defines.svh"

module pidt_ctrl import pidt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      cfg_valid,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	state_t     state_q, state_d;
	logic       launched_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_AD;
			launched_q <= 1'b0;
			cnt_q      <= 3'd0;
		end else begin
			state_q <= state_d;
			if (sts.done) begin
				launched_q <= 1'b0;
			end else if (cmd.start) begin
				launched_q <= 1'b1;
			end
			if (state_q == ST_MAC) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= 3'd0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.op  = OP_NONE;
		cmd.k   = cnt_q;
		unique case (state_q)
			ST_AD: begin
				cmd.op = OP_AD;
				if (sts.done) state_d = ST_DEN;
			end
			ST_DEN: begin
				cmd.op = OP_DEN;
				if (sts.done) state_d = ST_K1;
			end
			ST_K1: begin
				cmd.op = OP_K1;
				if (sts.done) state_d = ST_N0;
			end
			ST_N0: begin
				cmd.op = OP_N0;
				if (sts.done) state_d = ST_Q0;
			end
			ST_Q0: begin
				cmd.op = OP_Q0;
				if (sts.done) state_d = ST_TT;
			end
			ST_TT: begin
				cmd.op = OP_TT;
				if (sts.done) state_d = ST_DI;
			end
			ST_DI: begin
				cmd.op = OP_DI;
				if (sts.done) state_d = ST_N1;
			end
			ST_N1: begin
				cmd.op = OP_N1;
				if (sts.done) state_d = ST_Q1;
			end
			ST_Q1: begin
				cmd.op = OP_Q1;
				if (sts.done) state_d = ST_OUTER;
			end
			ST_OUTER: begin
				cmd.op = OP_OUTER;
				if (sts.done) state_d = ST_N2;
			end
			ST_N2: begin
				cmd.op = OP_N2;
				if (sts.done) state_d = ST_Q2;
			end
			ST_Q2: begin
				cmd.op = OP_Q2;
				if (sts.done) state_d = ST_Q3;
			end
			ST_Q3: begin
				cmd.op = OP_Q3;
				if (sts.done) state_d = ST_Q4;
			end
			ST_Q4: begin
				cmd.op = OP_Q4;
				if (sts.done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.cfg_ready = 1'b1;
				cmd.in_ready  = !cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_load = 1'b1;
					state_d      = ST_AD;
				end else if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.mac     = 1'b1;
				cmd.acc_clr = (cnt_q == 3'd0);
				if (cnt_q == 3'd4) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_RND;
			end
			ST_RND: begin
				cmd.rnd = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				if (sts.out_free) begin
					cmd.wr  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.start = (cmd.op != OP_NONE) && !launched_q;
	end

	`PIDT_ASSERT_NEXT(a_cfg_restarts, clk, arst_n, cmd.cfg_load, state_q == ST_AD, "config transfer did not restart the coefficient pass")
	`PIDT_ASSERT_NOW(a_done_launched, clk, arst_n, sts.done, launched_q, "unit finished without a start")
	`PIDT_ASSERT_NEXT(a_item_starts, clk, arst_n, cmd.in_load, state_q == ST_MAC && cnt_q == 3'd0, "accepted item did not start the mac sequence")

endmodule

>>> sv/pidt_dp.sv
`include "pid_controller_tustin_clamped_top_defines.svh"

module pidt_dp import pidt_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_cmd_t               cmd,
	output dp_sts_t                 sts,
	input  logic signed [ERR_W-1:0] error,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    drive_valid,
	input  logic                    drive_ready,
	output logic signed [DRV_W-1:0] drive
);

	localparam int AD_W  = 40;
	localparam int S_W   = 42;
	localparam int DEN_W = 66;
	localparam int TMP_W = 50;
	localparam int NUM_W = 75;
	localparam int MA_W  = 50;
	localparam int MB_W  = 33;
	localparam int P_W   = 76;
	localparam int DV_W  = (NUM_W + COEF_FRAC_BITS + 2 > DEN_W + 33) ?
		NUM_W + COEF_FRAC_BITS + 2 : DEN_W + 33;
	localparam int PR_W  = 48;
	localparam int ACC_W = 51;
	localparam int MAG_W = ACC_W + 1 - COEF_FRAC_BITS;

	// configuration
	logic [15:0] kp_q;
	logic [23:0] ti_q;
	logic [23:0] td_q;
	logic [15:0] al_q;
	logic [16:0] ts_q;

	// coefficient pass
	op_t              op_q;
	logic             mul_busy_q;
	logic             div_busy_q;
	logic             done_q;
	logic [AD_W-1:0]  ad_q;
	logic [DEN_W-1:0] den_q;
	logic [TMP_W-1:0] tmp_q;
	logic [NUM_W-1:0] num_q;
	logic             neg_q;
	logic [P_W-1:0]   a_sh_q;
	logic [MB_W-1:0]  b_sh_q;
	logic [P_W-1:0]   prod_q;
	logic [DV_W-1:0]  rem_q;
	logic [DV_W-1:0]  dsh_q;
	logic [4:0]       bit_q;
	logic [30:0]      quo_q;
	logic             den_zero_q;
	logic             div_neg_q;
	logic signed [31:0] coef_q [5];

	// item path
	logic signed [ERR_W-1:0]  err_q;
	logic signed [HIST_W-1:0] last_err_q;
	logic signed [HIST_W-1:0] older_err_q;
	logic signed [HIST_W-1:0] last_drv_q;
	logic signed [HIST_W-1:0] older_drv_q;
	logic signed [PR_W-1:0]   prod_s1;
	logic                     pv_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     rneg_q;
	logic                     drive_valid_q;
	logic signed [DRV_W-1:0]  drive_q;

	logic [25:0]        t2d_sum;
	logic [25:0]        t2i_sum;
	logic signed [25:0] t2d_dif;
	logic signed [25:0] t2i_dif;
	logic [24:0]        t2d_mag;
	logic [24:0]        t2i_mag;
	logic [S_W-1:0]     s_val;
	logic signed [42:0] r_val;
	logic [41:0]        r_mag;
	logic signed [50:0] mid;
	logic [49:0]        mid_mag;
	logic [MA_W-1:0]    mul_a;
	logic [MB_W-1:0]    mul_b;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic               div_neg_sel;
	logic               is_div;
	logic               mul_fin;
	logic               div_ge;
	logic [30:0]        quo_nxt;
	logic               div_fin;
	logic [30:0]        quo_fin;
	logic signed [31:0] coef_val;
	logic signed [31:0] coef_sel;
	logic signed [HIST_W-1:0] x_sel;
	logic [ACC_W-1:0]   acc_abs;
	logic [ACC_W:0]     mag_full;
	logic [DRV_W-1:0]   mag_cl;
	logic signed [DRV_W-1:0] res;

	always_comb begin
		t2d_sum = 26'(ts_q) + {1'b0, td_q, 1'b0};
		t2i_sum = 26'(ts_q) + {1'b0, ti_q, 1'b0};
		t2d_dif = $signed({9'd0, ts_q}) - $signed({1'b0, td_q, 1'b0});
		t2i_dif = $signed({9'd0, ts_q}) - $signed({1'b0, ti_q, 1'b0});
		t2d_mag = t2d_dif[25] ? 25'(-t2d_dif) : t2d_dif[24:0];
		t2i_mag = t2i_dif[25] ? 25'(-t2i_dif) : t2i_dif[24:0];
		s_val   = {9'd0, ts_q, 16'd0} + {1'b0, ad_q, 1'b0};
		r_val   = $signed({10'd0, ts_q, 16'd0}) - $signed({2'd0, ad_q, 1'b0});
		r_mag   = r_val[42] ? 42'(-r_val) : r_val[41:0];
		mid     = $signed({1'b0, tmp_q}) - $signed({1'b0, prod_q[47:0], 2'b00});
		mid_mag = mid[50] ? 50'(-mid) : mid[49:0];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_AD: begin
				mul_a = MA_W'(al_q);
				mul_b = MB_W'(td_q);
			end
			OP_DEN: begin
				mul_a = MA_W'(s_val);
				mul_b = MB_W'(ti_q);
			end
			OP_K1: begin
				mul_a = MA_W'(t2d_sum);
				mul_b = MB_W'(kp_q);
			end
			OP_N0: begin
				mul_a = tmp_q;
				mul_b = {t2i_sum, 7'd0};
			end
			OP_TT: begin
				mul_a = MA_W'(ts_q);
				mul_b = MB_W'(ts_q);
			end
			OP_DI: begin
				mul_a = MA_W'(td_q);
				mul_b = MB_W'(ti_q);
			end
			OP_N1: begin
				mul_a = tmp_q;
				mul_b = MB_W'({kp_q, 8'd0});
			end
			OP_OUTER: begin
				mul_a = MA_W'(t2d_mag);
				mul_b = MB_W'(t2i_mag);
			end
			OP_N2: begin
				mul_a = tmp_q;
				mul_b = MB_W'({kp_q, 7'd0});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_num     = num_q;
		div_den     = den_q;
		div_neg_sel = neg_q;
		is_div      = 1'b1;
		unique case (cmd.op)
			OP_Q0, OP_Q1, OP_Q2: begin
				div_num     = num_q;
				div_den     = den_q;
				div_neg_sel = neg_q;
			end
			OP_Q3: begin
				div_num     = NUM_W'({ad_q, 2'b00});
				div_den     = DEN_W'(s_val);
				div_neg_sel = 1'b0;
			end
			OP_Q4: begin
				div_num     = NUM_W'(r_mag);
				div_den     = DEN_W'(s_val);
				div_neg_sel = r_val[42];
			end
			default: begin
				is_div = 1'b0;
			end
		endcase
	end

	always_comb begin
		mul_fin = mul_busy_q && (b_sh_q == '0);
		div_ge  = (rem_q >= dsh_q);
		quo_nxt = quo_q;
		if (div_ge && bit_q != 5'd31) begin
			quo_nxt = quo_q | (31'd1 << bit_q);
		end
		div_fin = div_busy_q && (den_zero_q || (bit_q == 5'd31 && div_ge) || bit_q == 5'd0);
		if (den_zero_q) begin
			quo_fin = '0;
		end else if (bit_q == 5'd31) begin
			quo_fin = '1;
		end else begin
			quo_fin = quo_nxt;
		end
		coef_val = div_neg_q ? -$signed({1'b0, quo_fin}) : $signed({1'b0, quo_fin});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q          <= GAIN_RST;
			ti_q          <= INTEGRAL_RST;
			td_q          <= DERIVATIVE_RST;
			al_q          <= FILTER_RATIO_RST;
			ts_q          <= SAMPLE_RST;
			op_q          <= OP_NONE;
			mul_busy_q    <= 1'b0;
			div_busy_q    <= 1'b0;
			done_q        <= 1'b0;
			pv_s1         <= 1'b0;
			drive_valid_q <= 1'b0;
			last_err_q    <= '0;
			older_err_q   <= '0;
			last_drv_q    <= '0;
			older_drv_q   <= '0;
		end else begin
			done_q <= mul_fin || div_fin;
			pv_s1  <= cmd.mac;
			if (cmd.cfg_load) begin
				unique case (cfg_index)
					REG_GAIN:         kp_q <= cfg_data[15:0];
					REG_INTEGRAL:     ti_q <= cfg_data;
					REG_DERIVATIVE:   td_q <= cfg_data;
					REG_FILTER_RATIO: al_q <= cfg_data[15:0];
					REG_SAMPLE:       ts_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (cmd.start) begin
				op_q <= cmd.op;
				if (is_div) begin
					div_busy_q <= 1'b1;
				end else begin
					mul_busy_q <= 1'b1;
				end
			end
			if (mul_fin) mul_busy_q <= 1'b0;
			if (div_fin) div_busy_q <= 1'b0;
			if (cmd.wr) begin
				drive_valid_q <= 1'b1;
				older_err_q   <= last_err_q;
				last_err_q    <= err_q;
				older_drv_q   <= last_drv_q;
				last_drv_q    <= {res[DRV_W-1], res};
			end else if (drive_ready) begin
				drive_valid_q <= 1'b0;
			end
		end
	end

	// shift-add multiplier
	always_ff @(posedge clk) begin
		if (cmd.start && !is_div) begin
			a_sh_q <= P_W'(mul_a);
			b_sh_q <= mul_b;
			prod_q <= '0;
		end else if (mul_busy_q && b_sh_q != '0) begin
			if (b_sh_q[0]) prod_q <= prod_q + a_sh_q;
			a_sh_q <= a_sh_q << 1;
			b_sh_q <= b_sh_q >> 1;
		end
		if (mul_fin) begin
			unique case (op_q)
				OP_AD:  ad_q  <= prod_q[AD_W-1:0];
				OP_DEN: den_q <= prod_q[DEN_W-1:0];
				OP_K1, OP_TT: tmp_q <= prod_q[TMP_W-1:0];
				OP_OUTER: begin
					tmp_q <= prod_q[TMP_W-1:0];
					neg_q <= t2d_dif[25] ^ t2i_dif[25];
				end
				OP_DI: begin
					tmp_q <= mid_mag;
					neg_q <= mid[50];
				end
				OP_N0: begin
					num_q <= prod_q[NUM_W-1:0];
					neg_q <= 1'b0;
				end
				OP_N1, OP_N2: num_q <= prod_q[NUM_W-1:0];
				default: ;
			endcase
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start && is_div) begin
			rem_q      <= (DV_W'(div_num) << (COEF_FRAC_BITS + 1)) + DV_W'(div_den);
			dsh_q      <= DV_W'(div_den) << 32;
			bit_q      <= 5'd31;
			quo_q      <= '0;
			den_zero_q <= (div_den == '0);
			div_neg_q  <= div_neg_sel;
		end else if (div_busy_q && !div_fin) begin
			if (div_ge && bit_q != 5'd31) rem_q <= rem_q - dsh_q;
			quo_q <= quo_nxt;
			dsh_q <= dsh_q >> 1;
			bit_q <= bit_q - 5'd1;
		end
		if (div_fin) begin
			unique case (op_q)
				OP_Q0:   coef_q[0] <= coef_val;
				OP_Q1:   coef_q[1] <= coef_val;
				OP_Q2:   coef_q[2] <= coef_val;
				OP_Q3:   coef_q[3] <= coef_val;
				OP_Q4:   coef_q[4] <= coef_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		coef_sel = '0;
		x_sel    = '0;
		unique case (cmd.k)
			3'd0: begin
				coef_sel = coef_q[0];
				x_sel    = err_q;
			end
			3'd1: begin
				coef_sel = coef_q[1];
				x_sel    = last_err_q;
			end
			3'd2: begin
				coef_sel = coef_q[2];
				x_sel    = older_err_q;
			end
			3'd3: begin
				coef_sel = coef_q[3];
				x_sel    = last_drv_q;
			end
			3'd4: begin
				coef_sel = coef_q[4];
				x_sel    = older_drv_q;
			end
			default: begin
				coef_sel = '0;
				x_sel    = '0;
			end
		endcase
		acc_abs  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		mag_full = {1'b0, acc_abs} + ((ACC_W+1)'(1) << (COEF_FRAC_BITS - 1));
		mag_cl   = (mag_q >= MAG_W'(DRIVE_LIMIT)) ? DRIVE_LIMIT : mag_q[DRV_W-1:0];
		res      = rneg_q ? -$signed(mag_cl) : $signed(mag_cl);
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) err_q <= error;
		if (cmd.mac) prod_s1 <= coef_sel * x_sel;
		acc_q <= (cmd.acc_clr ? '0 : acc_q) +
			(pv_s1 ? {{(ACC_W-PR_W){prod_s1[PR_W-1]}}, prod_s1} : '0);
		if (cmd.rnd) begin
			mag_q  <= mag_full[ACC_W:COEF_FRAC_BITS];
			rneg_q <= acc_q[ACC_W-1];
		end
		if (cmd.wr) drive_q <= res;
	end

	assign sts.done     = done_q;
	assign sts.out_free = !drive_valid_q || drive_ready;
	assign drive_valid  = drive_valid_q;
	assign drive        = drive_q;

	`PIDT_ASSERT_NOW(a_units_exclusive, clk, arst_n, mul_busy_q, !div_busy_q, "multiplier and divider busy together")

endmodule

>>> sv/pid_controller_tustin_clamped_top.sv
// PID controller with filtered derivative, Tustin form, output limited to +/-12.0
//
// channels: samples takes one signed Q5.10 error per transfer, drives returns
// one signed Q4.10 drive value per sample, cfg writes the five registers
// (gain, integral time, derivative time, filter ratio, sample period).
// after reset and after every cfg transfer the five coefficients are rebuilt
// by a shift-add multiplier (one bit per cycle, nine products) and a restoring
// divider (one quotient bit per cycle, five quotients); while they run, samples
// and cfg are not ready. a sample runs through one 32x16 multiplier five times
// and is rounded and limited; the next sample is taken only once the drive
// value of the one before has been written to the output register.
// the drive output is a register: while the receiver stalls, the next sample
// is still taken and computed, then held until the register is free.
// reset clears the error and drive history and restores the default registers.
module pid_controller_tustin_clamped_top import pidt_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	pidt_error_if.sink   samples,
	pidt_drive_if.source drives,
	pidt_cfg_if.sink     cfg
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	pidt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.cfg_valid (cfg.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	pidt_dp #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.error       (samples.error),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.drive_valid (drives.valid),
		.drive_ready (drives.ready),
		.drive       (drives.drive)
	);

	assign samples.ready = cmd.in_ready;
	assign cfg.ready     = cmd.cfg_ready;

endmodule
